[rtl/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
// Used by fbpa_div, fixed_block_pool_allocator_top and fbpa_checker.
package fbpa_pkg;

    // Register field widths
    localparam int BS_W    = 21;   // block size
    localparam int CNT_W   = 9;    // block count and in-use count
    localparam int POOL_W  = 29;   // pool size in bytes
    localparam int MIN_BLOCK_BYTES = 64;

    // Divider: quotient bits needed to tell any index below the block count
    localparam int QW      = CNT_W;
    localparam int DVS_W   = BS_W + QW - 1;

    // Register indexes on the configuration port
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_POOL_VALID  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VIRT_BASE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHYS_BASE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_COUNT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POOL_BYTES  = 3'd5;

    // Result status codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [ST_W-1:0] ST_REFUSED = 3'd1;
    localparam logic [ST_W-1:0] ST_FREED   = 3'd2;
    localparam logic [ST_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    // Divider result handed back to the top level
    typedef struct packed {
        logic          done;   // one-cycle pulse when the quotient is ready
        logic          over;   // quotient is 2**QW or more
        logic [QW-1:0] quot;
    } t_div_res;

endpackage

[rtl/fbpa_div.sv]
// Restoring divider: pool offset over block size, one quotient bit a cycle.
// Depends on fbpa_pkg for widths and the result struct.
module fbpa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fbpa_pkg::POOL_W-1:0]  i_dividend,
    input  logic [fbpa_pkg::BS_W-1:0]    i_divisor,
    output fbpa_pkg::t_div_res           o_res
);

    localparam int CMP_W = (fbpa_pkg::POOL_W > fbpa_pkg::DVS_W) ?
                           fbpa_pkg::POOL_W : fbpa_pkg::DVS_W;
    localparam int STEP_W = $clog2(fbpa_pkg::QW + 1);

    logic                         r_busy;
    logic                         r_done;
    logic [STEP_W-1:0]            r_step;
    logic [fbpa_pkg::POOL_W-1:0]  r_rem;
    logic [fbpa_pkg::DVS_W-1:0]   r_dvs;
    logic [fbpa_pkg::QW-1:0]      r_quot;
    logic                         r_over;
    logic                         fits;

    // Trial compare of remainder against the shifted divisor
    assign fits = CMP_W'(r_rem) >= CMP_W'(r_dvs);

    // Control: load on start, count the steps down, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(fbpa_pkg::QW);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: subtract where it fits, shift the divisor down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dvs  <= fbpa_pkg::DVS_W'(i_divisor) << (fbpa_pkg::QW - 1);
            r_quot <= '0;
            r_over <= (i_dividend >> fbpa_pkg::QW) >= fbpa_pkg::POOL_W'(i_divisor);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - fbpa_pkg::POOL_W'(r_dvs);
            end
            r_quot <= {r_quot[fbpa_pkg::QW-2:0], fits};
            r_dvs  <= r_dvs >> 1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.over = r_over;
    assign o_res.quot = r_quot;

endmodule

[rtl/fixed_block_pool_allocator_top.sv]
// Fixed-size block pool allocator with a LIFO free-index stack in block RAM.
// Depends on fbpa_pkg and fbpa_div.
//
//  Channel  Dir  Handshake              Payload
//  s        in   i_s_tvalid/o_s_tready  tuser: req_type; tdata: free_addr
//  m        out  o_m_tvalid/i_m_tready  tuser: status;
//                                       tdata: block_pa, virt_addr, blocks_in_use
//  cfg      in   i_cfg_wen              i_cfg_index, i_cfg_wdata
//
//  One request is in flight at a time. Allocate: the result passes through decode
//  with stack RAM read, multiply, add and load before it is valid; the next
//  request is taken after the load. Free: the result waits on the nine-step divider.
//  Refused requests and frees ignored at decode go from decode straight to the load.
//  A finished result waits in the output register while the next request is
//  taken; a request that finishes while that register is still full holds.
//  Reset is synchronous; the stack needs no clearing pass, a low-water mark
//  stands in for the entries a block count write would load.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = 256,
    parameter int ADDR_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((ADDR_WIDTH+7)/8)*8-1:0]   i_s_tdata,  // free_addr
    input  logic                              i_s_tuser,  // req_type
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // block_pa, virt_addr, blocks_in_use
    output logic [((2*ADDR_WIDTH+fbpa_pkg::CNT_W+7)/8)*8-1:0] o_m_tdata,
    output logic [fbpa_pkg::ST_W-1:0]        o_m_tuser,  // status
    // configuration writes
    input  logic                              i_cfg_wen,
    input  logic [fbpa_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [((ADDR_WIDTH > fbpa_pkg::POOL_W) ? ADDR_WIDTH : fbpa_pkg::POOL_W)-1:0]
                                              i_cfg_wdata
);

    localparam int AW     = ADDR_WIDTH;
    localparam int IW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW     = $clog2(MAX_BLOCKS + 1);
    localparam int XW     = (AW > fbpa_pkg::POOL_W) ? AW : fbpa_pkg::POOL_W;
    localparam int DFW    = XW + 1;
    localparam int PRW    = IW + fbpa_pkg::BS_W;
    localparam int OUT_TDW = ((2*AW + fbpa_pkg::CNT_W + 7)/8)*8;
    localparam int CNT_MAX = (1 << fbpa_pkg::CNT_W) - 1;

    // State codes
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_POP_DATA = 3'd2;
    localparam logic [2:0] S_ADD      = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;

    // Configuration registers
    logic                          r_pool_valid;
    logic [AW-1:0]                 r_virt_base;
    logic [AW-1:0]                 r_phys_base;
    logic [fbpa_pkg::BS_W-1:0]     r_bs;          // effective block size
    logic [fbpa_pkg::CNT_W-1:0]    r_block_count;
    logic [fbpa_pkg::POOL_W-1:0]   r_pool_bytes;

    // Stack state
    logic [IW-1:0]                 r_stack [MAX_BLOCKS];
    logic [IW-1:0]                 r_rd_data;
    logic [SW-1:0]                 r_depth;
    logic [SW-1:0]                 r_low;         // lowest depth since reload
    logic [SW-1:0]                 r_fill_n;      // clamped count at reload
    logic [fbpa_pkg::CNT_W-1:0]    r_in_use;

    // Request and working registers
    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic                          r_req;
    logic [AW-1:0]                 r_addr;
    logic [SW-1:0]                 r_rd_pos;
    logic                          r_use_init;
    logic [PRW-1:0]                r_prod;
    logic [fbpa_pkg::ST_W-1:0]     r_status;
    logic [AW-1:0]                 r_pa;
    logic [AW-1:0]                 r_va;

    // Output register
    logic                          r_out_valid;
    logic [fbpa_pkg::ST_W-1:0]     r_out_status;
    logic [AW-1:0]                 r_out_pa;
    logic [AW-1:0]                 r_out_va;
    logic [fbpa_pkg::CNT_W-1:0]    r_out_biu;

    // Combinational helpers
    logic                          s_accept;
    logic                          out_free;
    logic [DFW-1:0]                dec_diff;
    logic                          dec_ignore;
    logic                          alloc_ok;
    logic [SW-1:0]                 pop_pos;
    logic [IW-1:0]                 pop_idx;
    logic                          free_bad_idx;
    logic                          stk_full;
    logic [SW-1:0]                 cfg_n;
    logic [fbpa_pkg::BS_W-1:0]     cfg_bs;
    fbpa_pkg::t_div_res            div_res;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_m_tready;

    // Decode: range check as one subtract and one compare, no wrap
    assign dec_diff   = DFW'(r_addr) - DFW'(r_virt_base);
    assign dec_ignore = !r_pool_valid || (r_addr == '0) || dec_diff[DFW-1] ||
                        (dec_diff >= DFW'(r_pool_bytes));
    assign alloc_ok   = r_pool_valid && (r_depth != '0);
    assign pop_pos    = r_depth - 1'b1;

    // Pop: entries below the low-water mark still hold their loaded value
    assign pop_idx = r_use_init ? IW'(r_fill_n - SW'(1) - r_rd_pos) : r_rd_data;

    // Free: quotient must lie below the block count and MAX_BLOCKS
    assign free_bad_idx = div_res.over ||
                          (div_res.quot >= r_block_count) ||
                          (32'(div_res.quot) >= MAX_BLOCKS);
    assign stk_full     = (r_depth == SW'(MAX_BLOCKS));

    // Configuration value conversions
    assign cfg_n  = (32'(i_cfg_wdata[fbpa_pkg::CNT_W-1:0]) > MAX_BLOCKS) ?
                    SW'(MAX_BLOCKS) : SW'(i_cfg_wdata[fbpa_pkg::CNT_W-1:0]);
    assign cfg_bs = (i_cfg_wdata[fbpa_pkg::BS_W-1:0] <
                     fbpa_pkg::BS_W'(fbpa_pkg::MIN_BLOCK_BYTES)) ?
                    fbpa_pkg::BS_W'(fbpa_pkg::MIN_BLOCK_BYTES) :
                    i_cfg_wdata[fbpa_pkg::BS_W-1:0];

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_DECODE) && r_req && !dec_ignore),
        .i_dividend (dec_diff[fbpa_pkg::POOL_W-1:0]),
        .i_divisor  (r_bs),
        .o_res      (div_res)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_req) begin
                    n_state = dec_ignore ? S_FIN : S_DIV;
                end else begin
                    n_state = alloc_ok ? S_POP_DATA : S_FIN;
                end
            end
            S_POP_DATA: n_state = S_ADD;
            S_ADD:      n_state = S_FIN;
            S_DIV: begin
                if (div_res.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Stack RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && div_res.done && !free_bad_idx && !stk_full) begin
            r_stack[IW'(r_depth)] <= IW'(div_res.quot);
        end
        if ((r_state == S_DECODE) && !r_req && alloc_ok) begin
            r_rd_data <= r_stack[IW'(pop_pos)];
        end
    end

    // Control state, configuration and stack pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pool_valid  <= 1'b0;
            r_virt_base   <= '0;
            r_phys_base   <= '0;
            r_bs          <= fbpa_pkg::BS_W'(fbpa_pkg::MIN_BLOCK_BYTES);
            r_block_count <= '0;
            r_pool_bytes  <= '0;
            r_depth       <= '0;
            r_low         <= '0;
            r_fill_n      <= '0;
            r_in_use      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes; a block count write reloads the stack
            if (i_cfg_wen) begin
                unique case (i_cfg_index)
                    fbpa_pkg::REG_POOL_VALID:  r_pool_valid <= i_cfg_wdata[0];
                    fbpa_pkg::REG_VIRT_BASE:   r_virt_base  <= i_cfg_wdata[AW-1:0];
                    fbpa_pkg::REG_PHYS_BASE:   r_phys_base  <= i_cfg_wdata[AW-1:0];
                    fbpa_pkg::REG_BLOCK_SIZE:  r_bs         <= cfg_bs;
                    fbpa_pkg::REG_BLOCK_COUNT: begin
                        r_block_count <= i_cfg_wdata[fbpa_pkg::CNT_W-1:0];
                        r_depth       <= cfg_n;
                        r_low         <= cfg_n;
                        r_fill_n      <= cfg_n;
                        r_in_use      <= '0;
                    end
                    fbpa_pkg::REG_POOL_BYTES:  r_pool_bytes <= i_cfg_wdata[fbpa_pkg::POOL_W-1:0];
                    default: ;
                endcase
            end

            // Pop: drop the depth and track the low-water mark
            if ((r_state == S_DECODE) && !r_req && alloc_ok) begin
                r_depth <= pop_pos;
                if (pop_pos < r_low) r_low <= pop_pos;
            end

            // Count the allocated block, saturating
            if ((r_state == S_POP_DATA) && (r_in_use != fbpa_pkg::CNT_W'(CNT_MAX))) begin
                r_in_use <= r_in_use + 1'b1;
            end

            // Push on a good free
            if ((r_state == S_DIV) && div_res.done && !free_bad_idx && !stk_full) begin
                r_depth <= r_depth + 1'b1;
                if (r_in_use != '0) r_in_use <= r_in_use - 1'b1;
            end

            // Output register valid
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req  <= i_s_tuser;
            r_addr <= i_s_tdata[AW-1:0];
        end
        if (r_state == S_DECODE) begin
            r_rd_pos   <= pop_pos;
            r_use_init <= pop_pos < r_low;
            if (r_req) begin
                r_status <= fbpa_pkg::ST_IGNORED;
            end else begin
                r_status <= fbpa_pkg::ST_REFUSED;
            end
        end
        if (r_state == S_POP_DATA) begin
            r_prod <= PRW'(pop_idx) * PRW'(r_bs);
        end
        if (r_state == S_ADD) begin
            r_pa     <= r_phys_base + AW'(r_prod);
            r_va     <= r_virt_base + AW'(r_prod);
            r_status <= fbpa_pkg::ST_ALLOC;
        end
        if ((r_state == S_DIV) && div_res.done) begin
            if (free_bad_idx) begin
                r_status <= fbpa_pkg::ST_IGNORED;
            end else if (stk_full) begin
                r_status <= fbpa_pkg::ST_FULL;
            end else begin
                r_status <= fbpa_pkg::ST_FREED;
            end
        end
        // Load the output beat; addresses only on a granted allocate
        if ((r_state == S_FIN) && out_free) begin
            r_out_status <= r_status;
            r_out_pa     <= (r_status == fbpa_pkg::ST_ALLOC) ? r_pa : '0;
            r_out_va     <= (r_status == fbpa_pkg::ST_ALLOC) ? r_va : '0;
            r_out_biu    <= r_in_use;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = OUT_TDW'({r_out_biu, r_out_va, r_out_pa});

endmodule

[rtl/fbpa_checker.sv]
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg for status codes and widths.
module fbpa_checker #(
    parameter int ADDR_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [((2*ADDR_WIDTH+fbpa_pkg::CNT_W+7)/8)*8-1:0] o_m_tdata,
    input  logic [fbpa_pkg::ST_W-1:0]        o_m_tuser
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // One request at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // Only a granted allocate carries addresses
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != fbpa_pkg::ST_ALLOC) |->
            o_m_tdata[2*ADDR_WIDTH-1:0] == '0)
        else $error("addresses on a result that is not an allocation");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= fbpa_pkg::ST_FULL)
        else $error("undefined status code");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_fbpa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[tb/fixed_block_pool_allocator_top_tb.sv]
// Self-checking testbench for fixed_block_pool_allocator_top: a directed plan and
// random phases checked against an in-bench model of the free-index stack.
// Depends on fbpa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_top_tb;

    localparam int MAX_BLOCKS  = 256;
    localparam int ADDR_WIDTH  = 48;
    localparam int RES_W       = 112;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 100;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;
    localparam logic [fbpa_pkg::CNT_W-1:0] COUNT_SAT = 9'h1FF;

    typedef struct packed {
        logic [fbpa_pkg::ST_W-1:0]  status;
        logic [ADDR_WIDTH-1:0]      pa;
        logic [ADDR_WIDTH-1:0]      va;
        logic [fbpa_pkg::CNT_W-1:0] used;
    } t_pool_result;

    typedef struct packed {
        bit                             is_cfg;
        logic [fbpa_pkg::REG_IDX_W-1:0] idx;
        logic [ADDR_WIDTH-1:0]          val;
        logic                           req;
        logic [ADDR_WIDTH-1:0]          addr;
        bit                             known;
        t_pool_result                   res;
    } t_plan_step;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [ADDR_WIDTH-1:0]          i_s_tdata;   // free_addr
    logic                           i_s_tuser;   // req_type
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [RES_W-1:0]               o_m_tdata;   // block_pa, virt_addr, blocks_in_use
    logic [fbpa_pkg::ST_W-1:0]      o_m_tuser;   // status
    logic                           i_cfg_wen;
    logic [fbpa_pkg::REG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_WIDTH-1:0]          i_cfg_wdata;

    // Pool model: registers and free-index stack
    logic                           pv_q;
    logic [ADDR_WIDTH-1:0]          vbase_q;
    logic [ADDR_WIDTH-1:0]          pbase_q;
    logic [fbpa_pkg::BS_W-1:0]      bsize_q;
    logic [fbpa_pkg::CNT_W-1:0]     bcount_q;
    logic [fbpa_pkg::POOL_W-1:0]    pbytes_q;
    logic [7:0]                     free_idx [MAX_BLOCKS];
    logic [fbpa_pkg::CNT_W-1:0]     depth_q;
    logic [fbpa_pkg::CNT_W-1:0]     in_use_q;

    t_pool_result                   pool_replies_due [$];
    t_plan_step                     directed_plan [$];
    bit                             idle_on;
    int                             pressure_cycles;
    int                             fail_cnt;

    fixed_block_pool_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Serve one request against the model and return the reply it should give
    function automatic t_pool_result serve_request(input logic req,
                                                   input logic [ADDR_WIDTH-1:0] addr);
        t_pool_result r;
        logic [fbpa_pkg::BS_W-1:0] bs;
        logic [7:0] blk;
        logic [ADDR_WIDTH-1:0] quot;
        r = '0;
        bs = (bsize_q < fbpa_pkg::BS_W'(fbpa_pkg::MIN_BLOCK_BYTES)) ?
             fbpa_pkg::BS_W'(fbpa_pkg::MIN_BLOCK_BYTES) : bsize_q;
        if (req == REQ_ALLOC) begin
            if (!pv_q || depth_q == '0) begin
                r.status = fbpa_pkg::ST_REFUSED;
            end else begin
                depth_q = depth_q - 1'b1;
                blk = free_idx[depth_q[7:0]];
                if (in_use_q != COUNT_SAT) in_use_q = in_use_q + 1'b1;
                r.pa = pbase_q + ADDR_WIDTH'(blk) * ADDR_WIDTH'(bs);
                r.va = vbase_q + ADDR_WIDTH'(blk) * ADDR_WIDTH'(bs);
                r.status = fbpa_pkg::ST_ALLOC;
            end
        end else if (!pv_q || addr == '0 || addr < vbase_q ||
                     {1'b0, addr} >= {1'b0, vbase_q} + (ADDR_WIDTH+1)'(pbytes_q)) begin
            r.status = fbpa_pkg::ST_IGNORED;
        end else begin
            quot = (addr - vbase_q) / ADDR_WIDTH'(bs);
            if (quot >= ADDR_WIDTH'(bcount_q) || quot >= ADDR_WIDTH'(MAX_BLOCKS)) begin
                r.status = fbpa_pkg::ST_IGNORED;
            end else if (int'(depth_q) >= MAX_BLOCKS) begin
                r.status = fbpa_pkg::ST_FULL;
            end else begin
                free_idx[depth_q[7:0]] = quot[7:0];
                depth_q = depth_q + 1'b1;
                if (in_use_q != '0) in_use_q = in_use_q - 1'b1;
                r.status = fbpa_pkg::ST_FREED;
            end
        end
        r.used = in_use_q;
        return r;
    endfunction

    function automatic logic [ADDR_WIDTH-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_WIDTH-1:0];
    endfunction

    function automatic t_plan_step cfg_step(input logic [fbpa_pkg::REG_IDX_W-1:0] idx,
                                            input logic [ADDR_WIDTH-1:0] val);
        t_plan_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic t_plan_step req_step(input logic req,
                                            input logic [ADDR_WIDTH-1:0] addr);
        t_plan_step s;
        s = '0;
        s.req = req;
        s.addr = addr;
        return s;
    endfunction

    function automatic t_plan_step known_step(input logic req,
                                              input logic [ADDR_WIDTH-1:0] addr,
                                              input logic [fbpa_pkg::ST_W-1:0] st,
                                              input logic [ADDR_WIDTH-1:0] pa,
                                              input logic [ADDR_WIDTH-1:0] va,
                                              input logic [fbpa_pkg::CNT_W-1:0] used);
        t_plan_step s;
        s = req_step(req, addr);
        s.known = 1'b1;
        s.res = '{status: st, pa: pa, va: va, used: used};
        return s;
    endfunction

    // Append one row to the directed plan
    function automatic void plan_row(input t_plan_step s);
        directed_plan.insert(directed_plan.size(), s);
    endfunction

    // Offer one request beat, wait for it to be taken, then queue its reply
    task automatic send_req(input logic req, input logic [ADDR_WIDTH-1:0] addr,
                            input bit known, input t_pool_result known_res,
                            output t_pool_result reply);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= addr;
        do @(posedge i_clk); while (!o_s_tready);
        reply = serve_request(req, addr);
        pool_replies_due.insert(pool_replies_due.size(), known ? known_res : reply);
    endtask

    // Drop the request valid and wait until every reply has come back
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pool_replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the model; a block count write reloads
    task automatic write_reg(input logic [fbpa_pkg::REG_IDX_W-1:0] idx,
                             input logic [ADDR_WIDTH-1:0] val);
        int n;
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            fbpa_pkg::REG_POOL_VALID:  pv_q = val[0];
            fbpa_pkg::REG_VIRT_BASE:   vbase_q = val;
            fbpa_pkg::REG_PHYS_BASE:   pbase_q = val;
            fbpa_pkg::REG_BLOCK_SIZE:  bsize_q = val[fbpa_pkg::BS_W-1:0];
            fbpa_pkg::REG_POOL_BYTES:  pbytes_q = val[fbpa_pkg::POOL_W-1:0];
            fbpa_pkg::REG_BLOCK_COUNT: begin
                bcount_q = val[fbpa_pkg::CNT_W-1:0];
                n = (int'(bcount_q) > MAX_BLOCKS) ? MAX_BLOCKS : int'(bcount_q);
                for (int i = 0; i < MAX_BLOCKS; i++) free_idx[i] = 8'd0;
                for (int i = 0; i < n; i++) free_idx[i] = 8'(n - 1 - i);
                depth_q = fbpa_pkg::CNT_W'(n);
                in_use_q = '0;
            end
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Result side: check each reply beat, stall in random bursts or on request
    initial begin : result_sink
        t_pool_result want;
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (pool_replies_due.size() == 0) begin
                    $error("reply beat with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = pool_replies_due.pop_front();
                    if (o_m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                        fail_cnt++;
                    end
                    if (o_m_tdata[47:0] !== want.pa) begin
                        $error("block_pa: expected %h, got %h", want.pa, o_m_tdata[47:0]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[95:48] !== want.va) begin
                        $error("virt_addr: expected %h, got %h", want.va, o_m_tdata[95:48]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[104:96] !== want.used) begin
                        $error("blocks_in_use: expected %0d, got %0d",
                               want.used, o_m_tdata[104:96]);
                        fail_cnt++;
                    end
                end
            end
            if (pressure_cycles != 0) begin
                hold_left = pressure_cycles;
                pressure_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Abort when neither side has moved a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_pool_result reply;
        t_plan_step s;
        logic [ADDR_WIDTH-1:0] live [$];
        logic [ADDR_WIDTH-1:0] vals [6];
        logic [ADDR_WIDTH-1:0] addr;
        logic [ADDR_WIDTH-1:0] last_freed;
        logic [fbpa_pkg::REG_IDX_W-1:0] order [6];
        logic [fbpa_pkg::REG_IDX_W-1:0] tmp_idx;
        logic req;
        longint bs_eff;
        longint n_eff;
        longint span_bytes;
        int j;
        int sel;

        fail_cnt = 0;
        pressure_cycles = 0;
        idle_on = 1'b1;
        last_freed = '0;
        pv_q = 1'b0;
        vbase_q = '0;
        pbase_q = '0;
        bsize_q = fbpa_pkg::BS_W'(fbpa_pkg::MIN_BLOCK_BYTES);
        bcount_q = '0;
        pbytes_q = '0;
        depth_q = '0;
        in_use_q = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) free_idx[i] = 8'd0;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= REQ_ALLOC;
        i_cfg_wen   <= 1'b0;
        i_cfg_index <= fbpa_pkg::REG_POOL_VALID;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan: reset state, refusals, small block size, range checks,
        // double free, oversized count with a full stack, address wrap, pool off
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_REFUSED, 0, 0, 0));
        plan_row(known_step(REQ_FREE, 48'h40, fbpa_pkg::ST_IGNORED, 0, 0, 0));
        plan_row(cfg_step(fbpa_pkg::REG_POOL_VALID, 48'h1));
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_REFUSED, 0, 0, 0));
        plan_row(cfg_step(fbpa_pkg::REG_VIRT_BASE, 48'h0000_1000_0000));
        plan_row(cfg_step(fbpa_pkg::REG_PHYS_BASE, 48'h0000_8000_0000));
        plan_row(cfg_step(fbpa_pkg::REG_BLOCK_SIZE, 48'h0));
        plan_row(cfg_step(fbpa_pkg::REG_POOL_BYTES, 48'd512));
        plan_row(cfg_step(fbpa_pkg::REG_BLOCK_COUNT, 48'd4));
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_ALLOC,
                            48'h8000_0000, 48'h1000_0000, 1));
        plan_row(known_step(REQ_ALLOC, 48'hFFFF_FFFF_FFFF, fbpa_pkg::ST_ALLOC,
                            48'h8000_0040, 48'h1000_0040, 2));
        plan_row(req_step(REQ_FREE, 48'h1000_007F));
        plan_row(known_step(REQ_FREE, 48'h0, fbpa_pkg::ST_IGNORED, 0, 0, 1));
        plan_row(known_step(REQ_FREE, 48'h0FFF_FFFF, fbpa_pkg::ST_IGNORED, 0, 0, 1));
        plan_row(known_step(REQ_FREE, 48'h1000_0100, fbpa_pkg::ST_IGNORED, 0, 0, 1));
        plan_row(known_step(REQ_FREE, 48'h1000_0200, fbpa_pkg::ST_IGNORED, 0, 0, 1));
        plan_row(req_step(REQ_FREE, 48'h1000_0000));
        plan_row(req_step(REQ_FREE, 48'h1000_0000));
        plan_row(req_step(REQ_ALLOC, 48'h0));
        plan_row(cfg_step(fbpa_pkg::REG_BLOCK_COUNT, 48'd511));
        plan_row(known_step(REQ_FREE, 48'h1000_0000, fbpa_pkg::ST_FULL, 0, 0, 0));
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_ALLOC,
                            48'h8000_0000, 48'h1000_0000, 1));
        plan_row(cfg_step(fbpa_pkg::REG_VIRT_BASE, 48'hFFFF_FFFF_FFC0));
        plan_row(cfg_step(fbpa_pkg::REG_PHYS_BASE, 48'hFFFF_FFFF_FFFF));
        plan_row(cfg_step(fbpa_pkg::REG_BLOCK_SIZE, 48'h1F_FFFF));
        plan_row(cfg_step(fbpa_pkg::REG_POOL_BYTES, 48'h1FFF_FFFF));
        plan_row(cfg_step(fbpa_pkg::REG_BLOCK_COUNT, 48'd2));
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_ALLOC,
                            48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFC0, 1));
        plan_row(req_step(REQ_ALLOC, 48'h0));
        plan_row(req_step(REQ_FREE, 48'hFFFF_FFFF_FFFF));
        plan_row(req_step(REQ_ALLOC, 48'h0));
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_REFUSED, 0, 0, 2));
        plan_row(cfg_step(fbpa_pkg::REG_POOL_VALID, 48'h0));
        plan_row(known_step(REQ_FREE, 48'hFFFF_FFFF_FFC0, fbpa_pkg::ST_IGNORED, 0, 0, 2));
        plan_row(known_step(REQ_ALLOC, 48'h0, fbpa_pkg::ST_REFUSED, 0, 0, 2));

        foreach (directed_plan[k]) begin
            s = directed_plan[k];
            if (s.is_cfg) begin
                settle();
                write_reg(s.idx, s.val);
            end else begin
                send_req(s.req, s.addr, s.known, s.res, reply);
            end
        end

        // Random phases: fresh pool setting, then mostly alloc/free pairs with noise
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            idle_on = !(ph == 2 || ph >= PHASES - 3);

            sel = $urandom_range(0, 9);
            if (sel == 0)
                vals[fbpa_pkg::REG_BLOCK_SIZE] = ADDR_WIDTH'($urandom_range(0, 63));
            else if (sel == 1)
                vals[fbpa_pkg::REG_BLOCK_SIZE] = ADDR_WIDTH'(64);
            else if (sel == 2)
                vals[fbpa_pkg::REG_BLOCK_SIZE] = ADDR_WIDTH'($urandom_range(0, 32'h1F_FFFF));
            else
                vals[fbpa_pkg::REG_BLOCK_SIZE] = ADDR_WIDTH'($urandom_range(64, 4096));
            bs_eff = (vals[fbpa_pkg::REG_BLOCK_SIZE] <
                      ADDR_WIDTH'(fbpa_pkg::MIN_BLOCK_BYTES)) ?
                     longint'(fbpa_pkg::MIN_BLOCK_BYTES) :
                     longint'(vals[fbpa_pkg::REG_BLOCK_SIZE]);

            sel = $urandom_range(0, 9);
            if (sel == 0)
                vals[fbpa_pkg::REG_BLOCK_COUNT] = '0;
            else if (sel == 1)
                vals[fbpa_pkg::REG_BLOCK_COUNT] = ADDR_WIDTH'(MAX_BLOCKS);
            else if (sel == 2)
                vals[fbpa_pkg::REG_BLOCK_COUNT] =
                    ADDR_WIDTH'($urandom_range(MAX_BLOCKS + 1, 511));
            else
                vals[fbpa_pkg::REG_BLOCK_COUNT] = ADDR_WIDTH'($urandom_range(1, 16));
            n_eff = (vals[fbpa_pkg::REG_BLOCK_COUNT] > ADDR_WIDTH'(MAX_BLOCKS)) ?
                    longint'(MAX_BLOCKS) : longint'(vals[fbpa_pkg::REG_BLOCK_COUNT]);

            span_bytes = n_eff * bs_eff + longint'($urandom_range(0, 32'(bs_eff)));
            if ($urandom_range(0, 7) == 0)
                span_bytes = longint'($urandom_range(0, 32'h1FFF_FFFF));
            if (span_bytes > 64'h1FFF_FFFF) span_bytes = 64'h1FFF_FFFF;
            vals[fbpa_pkg::REG_POOL_BYTES] = ADDR_WIDTH'(span_bytes);

            sel = $urandom_range(0, 5);
            if (sel == 0)
                vals[fbpa_pkg::REG_VIRT_BASE] = 48'hFFFF_FFFF_FFFF -
                                                ADDR_WIDTH'($urandom_range(0, 4095));
            else if (sel == 1)
                vals[fbpa_pkg::REG_VIRT_BASE] = '0;
            else
                vals[fbpa_pkg::REG_VIRT_BASE] = rand_addr();
            vals[fbpa_pkg::REG_PHYS_BASE]  = rand_addr();
            vals[fbpa_pkg::REG_POOL_VALID] = ADDR_WIDTH'($urandom_range(0, 7) != 0);

            // Write the registers in a shuffled order
            for (int i = 0; i < 6; i++) order[i] = fbpa_pkg::REG_IDX_W'(i);
            for (int i = 5; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp_idx = order[i];
                order[i] = order[j];
                order[j] = tmp_idx;
            end
            for (int i = 0; i < 6; i++) write_reg(order[i], vals[order[i]]);
            live.delete();

            // Hold the reply side off so the block backs up into its input
            if (ph == 5) pressure_cycles = 300;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 45 || (sel < 80 && live.size() == 0)) begin
                    req = REQ_ALLOC;
                    addr = rand_addr();
                end else if (sel < 80) begin
                    req = REQ_FREE;
                    j = $urandom_range(0, live.size() - 1);
                    addr = live[j] + ADDR_WIDTH'($urandom_range(0, 32'(bs_eff - 1)));
                    last_freed = live[j];
                    live.delete(j);
                end else begin
                    req = REQ_FREE;
                    case ($urandom_range(0, 4))
                        0: addr = '0;
                        1: addr = rand_addr();
                        2: addr = last_freed;
                        3: addr = vals[fbpa_pkg::REG_VIRT_BASE] +
                                  vals[fbpa_pkg::REG_POOL_BYTES] +
                                  ADDR_WIDTH'($urandom_range(0, 255));
                        default: addr = vals[fbpa_pkg::REG_VIRT_BASE] +
                                        ADDR_WIDTH'(longint'(vals[fbpa_pkg::REG_BLOCK_COUNT])
                                                    * bs_eff) +
                                        ADDR_WIDTH'($urandom_range(0, 32'(bs_eff - 1)));
                    endcase
                end
                send_req(req, addr, 1'b0, '0, reply);
                if (req == REQ_ALLOC && reply.status == fbpa_pkg::ST_ALLOC)
                    live.insert(live.size(), reply.va);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        fail_cnt += pool_replies_due.size();
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
